[hw/rtl/lhrr_pkg.sv]
// shared constants, register indexes and helper functions for the hashing block
package lhrr_pkg;

  localparam int USER_AW  = 12;
  localparam int POI_AW   = 12;
  localparam int HASH_W   = 4;
  localparam int CODE_W   = 8;
  localparam int DIV_W    = 9;
  localparam int PAIR_AW  = HASH_W + POI_AW;
  localparam int WORD_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CODES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_LIM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA       = 2'd3;

  localparam logic [4:0]  HASH_MAX = 5'd16;
  localparam logic [8:0]  CODE_MAX = 9'd256;

  function automatic logic [DIV_W-1:0] eff_hashes(input logic [4:0] h);
    logic [4:0] v;
    v = h;
    if (v == 5'd0) v = 5'd1;
    if (v > HASH_MAX) v = HASH_MAX;
    return {4'd0, v};
  endfunction

  function automatic logic [DIV_W-1:0] eff_codes(input logic [8:0] c);
    logic [8:0] v;
    v = c;
    if (v == 9'd0) v = 9'd1;
    if (v > CODE_MAX) v = CODE_MAX;
    return v;
  endfunction

endpackage

[hw/rtl/lhrr_in_if.sv]
// input record channel
interface lhrr_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] user_id;
  logic [11:0] poi_id;
  logic [31:0] rand_hash;
  logic [31:0] rand_code;
  logic [31:0] rand_coin;
  logic [31:0] rand_fake;
  modport source (output valid, user_id, poi_id, rand_hash, rand_code, rand_coin, rand_fake,
                  input ready);
  modport sink (input valid, user_id, poi_id, rand_hash, rand_code, rand_coin, rand_fake,
                output ready);
endinterface

[hw/rtl/lhrr_out_if.sv]
// result channel
interface lhrr_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_user;
  logic [7:0]  obf_code;
  logic [7:0]  true_code;
  modport source (output valid, out_user, obf_code, true_code, input ready);
  modport sink (input valid, out_user, obf_code, true_code, output ready);
endinterface

[hw/rtl/lhrr_ram.sv]
// generic single-port-write ram with registered read
module lhrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

[hw/rtl/lhrr_mod.sv]
// bit-serial remainder of a 32-bit word by a small divisor
module lhrr_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lhrr_pkg::WORD_W-1:0] dividend,
  input  logic [lhrr_pkg::DIV_W-1:0]  divisor,
  output logic                      done,
  output logic [lhrr_pkg::CODE_W-1:0] rem
);
  import lhrr_pkg::*;

  logic [WORD_W-1:0] quo_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  div_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_W:0]    shifted;
  logic [DIV_W-1:0]  rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[WORD_W-1]};
    if (shifted >= {1'b0, div_r}) rem_nxt = DIV_W'(shifted - {1'b0, div_r});
    else rem_nxt = DIV_W'(shifted);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 5'd31);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[WORD_W-2:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r[CODE_W-1:0];
endmodule

[hw/rtl/local_hash_randomized_response.sv]
// top level: local hashing with randomized response over location records
//
// in_ch carries one location record per beat (user, point, four random words);
// out_ch carries at most one result beat per record. cfg_we/cfg_idx/cfg_data
// write the four settings registers; write them only while the block is idle.
// A kept record runs to the end before the next record is taken: its result goes
// into the output register for out_ch, and then in_ch.ready rises again. Three
// bit-serial remainder units run side by side, then the user table and the pair
// table are read, updated and written back one after the other. A record past the
// trace limit is taken and yields no result.
// After reset the block sweeps both tables, one entry per cycle, with in_ch.ready
// low; configuration writes are taken meanwhile.
// Results wait in an output register; the next record is accepted while a
// result waits, and the block holds its finished record when out_ch stalls.
module local_hash_randomized_response (
  input  logic                            clk,
  input  logic                            rst_n,
  lhrr_in_if.sink                         in_ch,
  lhrr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lhrr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lhrr_pkg::WORD_W-1:0]     cfg_data
);
  import lhrr_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_WAIT, S_PRD, S_PAIR} state_t;

  state_t state_r;

  logic [4:0]  num_hashes_r;
  logic [8:0]  num_codes_r;
  logic [15:0] trace_limit_r;
  logic [31:0] beta_r;

  logic [PAIR_AW-1:0] clr_idx_r;
  logic               seen_r;
  logic [USER_AW-1:0] last_user_r;
  logic [15:0]        run_pos_r;

  logic [USER_AW-1:0] user_r;
  logic [POI_AW-1:0]  poi_r;
  logic [31:0]        coin_r;
  logic [HASH_W-1:0]  hidx_r;

  logic               out_valid_r;
  logic [USER_AW-1:0] out_user_r;
  logic [CODE_W-1:0]  obf_r;
  logic [CODE_W-1:0]  true_r;

  // record accept and run bookkeeping
  logic        accept;
  logic        same_user;
  logic [15:0] pos_eff;
  logic        drop;
  logic        start;

  assign accept    = in_ch.valid && in_ch.ready;
  assign same_user = seen_r && (in_ch.user_id == last_user_r);
  assign pos_eff   = same_user ? run_pos_r : 16'd0;
  assign drop      = (trace_limit_r != 16'd0) && (pos_eff >= trace_limit_r);
  assign start     = accept && !drop;

  // remainder units
  logic              hash_done, code_done, fake_done;
  logic [CODE_W-1:0] hash_rem, code_rem, fake_rem;

  lhrr_mod u_mod_hash (
    .clk, .rst_n, .start,
    .dividend (in_ch.rand_hash), .divisor (eff_hashes(num_hashes_r)),
    .done (hash_done), .rem (hash_rem)
  );
  lhrr_mod u_mod_code (
    .clk, .rst_n, .start,
    .dividend (in_ch.rand_code), .divisor (eff_codes(num_codes_r)),
    .done (code_done), .rem (code_rem)
  );
  lhrr_mod u_mod_fake (
    .clk, .rst_n, .start,
    .dividend (in_ch.rand_fake), .divisor (eff_codes(num_codes_r)),
    .done (fake_done), .rem (fake_rem)
  );

  // tables: valid bit on top of each entry
  logic                user_we;
  logic [USER_AW-1:0]  user_waddr;
  logic [HASH_W:0]     user_wdata;
  logic [HASH_W:0]     user_rd;
  logic                pair_we;
  logic [PAIR_AW-1:0]  pair_waddr;
  logic [CODE_W:0]     pair_wdata;
  logic [CODE_W:0]     pair_rd;
  logic [HASH_W-1:0]   hidx_now;
  logic [CODE_W-1:0]   code_now;
  logic                pair_done;

  assign hidx_now  = user_rd[HASH_W] ? user_rd[HASH_W-1:0] : hash_rem[HASH_W-1:0];
  assign code_now  = pair_rd[CODE_W] ? pair_rd[CODE_W-1:0] : code_rem;
  assign pair_done = (state_r == S_PAIR) && (!out_valid_r || out_ch.ready);

  always_comb begin
    if (state_r == S_CLEAR) begin
      user_we    = 1'b1;
      user_waddr = clr_idx_r[USER_AW-1:0];
      user_wdata = '0;
      pair_we    = 1'b1;
      pair_waddr = clr_idx_r;
      pair_wdata = '0;
    end else begin
      user_we    = (state_r == S_WAIT) && hash_done && !user_rd[HASH_W];
      user_waddr = user_r;
      user_wdata = {1'b1, hash_rem[HASH_W-1:0]};
      pair_we    = pair_done && !pair_rd[CODE_W];
      pair_waddr = {hidx_r, poi_r};
      pair_wdata = {1'b1, code_rem};
    end
  end

  lhrr_ram #(.WIDTH(HASH_W + 1), .DEPTH(1 << USER_AW)) u_user_ram (
    .clk, .wr_en (user_we), .wr_addr (user_waddr), .wr_data (user_wdata),
    .rd_addr (user_r), .rd_data (user_rd)
  );

  lhrr_ram #(.WIDTH(CODE_W + 1), .DEPTH(1 << PAIR_AW)) u_pair_ram (
    .clk, .wr_en (pair_we), .wr_addr (pair_waddr), .wr_data (pair_wdata),
    .rd_addr ({hidx_r, poi_r}), .rd_data (pair_rd)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_hashes_r  <= 5'd1;
      num_codes_r   <= 9'd2;
      trace_limit_r <= 16'd1;
      beta_r        <= '1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NUM_HASHES: num_hashes_r  <= cfg_data[4:0];
        CFG_NUM_CODES:  num_codes_r   <= cfg_data[8:0];
        CFG_TRACE_LIM:  trace_limit_r <= cfg_data[15:0];
        CFG_BETA:       beta_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      seen_r      <= 1'b0;
      run_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!pair_done && out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + PAIR_AW'(1);
          if (&clr_idx_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            user_r      <= in_ch.user_id;
            poi_r       <= in_ch.poi_id;
            coin_r      <= in_ch.rand_coin;
            seen_r      <= 1'b1;
            last_user_r <= in_ch.user_id;
            run_pos_r   <= (pos_eff == 16'hFFFF) ? pos_eff : pos_eff + 16'd1;
            state_r     <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (hash_done) begin
            hidx_r  <= hidx_now;
            state_r <= S_PRD;
          end
        end
        S_PRD: state_r <= S_PAIR;
        S_PAIR: begin
          if (pair_done) begin
            out_valid_r <= 1'b1;
            out_user_r  <= user_r;
            true_r      <= code_now;
            obf_r       <= (coin_r <= beta_r) ? code_now : fake_rem;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_user  = out_user_r;
  assign out_ch.obf_code  = obf_r;
  assign out_ch.true_code = true_r;

  // checks
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!out_valid_r && !in_ch.ready))
    else $error("activity during table clear");

  a_mods_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (hash_done == code_done) && (code_done == fake_done))
    else $error("remainder units out of step");

  a_drop_no_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && drop) |=> ($stable(run_pos_r) && state_r == S_IDLE))
    else $error("dropped record changed state");
endmodule
